// ===== sv/xcfr_pkg.sv =====
// Shared types and constants for the checksummed frame receiver.
package xcfr_pkg;

    localparam logic [7:0] SOF_BYTE = 8'hFE;
    localparam int LEN_W = 16;
    localparam int POS_W = 6;

    typedef enum logic [3:0] {
        S_WAIT,
        S_FMSB,
        S_FLSB,
        S_LMSB,
        S_LLSB,
        S_DATA,
        S_CSUM,
        S_READ,
        S_SEND
    } t_state;

    typedef struct packed {
        logic sof;
        logic ld_fmsb;
        logic ld_flsb;
        logic ld_lmsb;
        logic ld_llsb;
        logic store;
        logic emit_start;
        logic rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sof_hit;
        logic len_next_zero;
        logic len_zero;
        logic len_over;
        logic fill_done;
        logic csum_ok;
        logic last_k;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/xcfr_ctrl.sv =====
// Frame receiver controller: header parsing, payload fill and emission sequencing.
module xcfr_ctrl
    import xcfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_rx_valid,
    output logic o_rx_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign o_rx_stall = (r_state == S_READ) || (r_state == S_SEND);
    assign acc        = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_WAIT: begin
                if (acc && i_sts.sof_hit) begin
                    o_cmd.sof = 1'b1;
                    n_state   = S_FMSB;
                end
            end
            S_FMSB: begin
                if (acc) begin
                    o_cmd.ld_fmsb = 1'b1;
                    n_state       = S_FLSB;
                end
            end
            S_FLSB: begin
                if (acc) begin
                    o_cmd.ld_flsb = 1'b1;
                    n_state       = S_LMSB;
                end
            end
            S_LMSB: begin
                if (acc) begin
                    o_cmd.ld_lmsb = 1'b1;
                    n_state       = S_LLSB;
                end
            end
            S_LLSB: begin
                if (acc) begin
                    o_cmd.ld_llsb = 1'b1;
                    n_state       = i_sts.len_next_zero ? S_CSUM : S_DATA;
                end
            end
            S_DATA: begin
                if (acc) begin
                    if (i_sts.len_over) begin
                        n_state = S_WAIT;
                    end else begin
                        o_cmd.store = 1'b1;
                        if (i_sts.fill_done) begin
                            n_state = S_CSUM;
                        end
                    end
                end
            end
            S_CSUM: begin
                if (acc) begin
                    if (i_sts.csum_ok) begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = i_sts.len_zero ? S_SEND : S_READ;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.last_k ? S_WAIT : S_READ;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    a_read_then_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_SEND)
        else $error("buffer read not followed by send");

    a_bad_csum_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CSUM && acc && !i_sts.csum_ok) |=> r_state == S_WAIT)
        else $error("bad checksum did not drop frame");

    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND || r_state == S_READ) |-> !acc)
        else $error("item accepted during emission");

endmodule

// ===== sv/xcfr_dpath.sv =====
// Frame receiver datapath: header registers, checksum, payload buffer and output register.
module xcfr_dpath
    import xcfr_pkg::*;
#(
    parameter int P = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [15:0]       o_func_code,
    output logic [5:0]        o_payload_len,
    output logic [7:0]        o_data_byte,
    output logic [POS_W-1:0]  o_byte_pos,
    output logic              o_last_flag
);

    localparam int AW = $clog2(P);

    logic [7:0]       mem [P];
    logic [15:0]      r_func;
    logic [LEN_W-1:0] r_len;
    logic [AW-1:0]    r_fill;
    logic [7:0]       r_xor;
    logic [AW-1:0]    r_k;
    logic [7:0]       r_rd_data;
    logic             r_out_valid;
    logic [15:0]      r_o_func;
    logic [5:0]       r_o_len;
    logic [7:0]       r_o_data;
    logic [POS_W-1:0] r_o_pos;
    logic             r_o_last;
    logic [AW:0]      fill_inc;
    logic [AW:0]      k_inc;

    assign fill_inc = {1'b0, r_fill} + 1'b1;
    assign k_inc    = {1'b0, r_k} + 1'b1;

    assign o_sts.sof_hit       = (i_rx_byte == SOF_BYTE);
    assign o_sts.len_next_zero = (r_len[15:8] == 8'd0) && (i_rx_byte == 8'd0);
    assign o_sts.len_zero      = (r_len == '0);
    assign o_sts.len_over      = (r_len >= LEN_W'(P));
    assign o_sts.fill_done     = (LEN_W'(fill_inc) >= r_len);
    assign o_sts.csum_ok       = (r_xor == i_rx_byte);
    assign o_sts.last_k        = (LEN_W'(k_inc) >= r_len);
    assign o_sts.out_free      = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[r_fill] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sof) begin
            r_xor  <= SOF_BYTE;
            r_fill <= '0;
        end
        if (i_cmd.ld_fmsb || i_cmd.ld_flsb || i_cmd.ld_lmsb || i_cmd.ld_llsb
            || i_cmd.store) begin
            r_xor <= r_xor ^ i_rx_byte;
        end
        if (i_cmd.ld_fmsb) begin
            r_func[15:8] <= i_rx_byte;
        end
        if (i_cmd.ld_flsb) begin
            r_func[7:0] <= i_rx_byte;
        end
        if (i_cmd.ld_lmsb) begin
            r_len[15:8] <= i_rx_byte;
        end
        if (i_cmd.ld_llsb) begin
            r_len[7:0] <= i_rx_byte;
            r_fill     <= '0;
        end
        if (i_cmd.store) begin
            r_fill <= o_sts.fill_done ? '0 : fill_inc[AW-1:0];
        end
        if (i_cmd.emit_start) begin
            r_k <= '0;
        end
        if (i_cmd.out_load) begin
            r_k      <= k_inc[AW-1:0];
            r_o_func <= r_func;
            r_o_len  <= r_len[5:0];
            r_o_data <= o_sts.len_zero ? 8'd0 : r_rd_data;
            r_o_pos  <= POS_W'(r_k);
            r_o_last <= o_sts.last_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_func_code   = r_o_func;
    assign o_payload_len = r_o_len;
    assign o_data_byte   = r_o_data;
    assign o_byte_pos    = r_o_pos;
    assign o_last_flag   = r_o_last;

    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_len < LEN_W'(P)) && (LEN_W'(r_fill) < r_len))
        else $error("payload write outside frame");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && !o_sts.len_zero) |-> (LEN_W'(r_k) < r_len))
        else $error("emission beyond frame length");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_sts.out_free)
        else $error("output item overwritten while stalled");

endmodule

// ===== sv/xor_checksum_frame_receiver_unit.sv =====
// Top level of the XOR-checksummed frame receiver.
// Bytes are taken one per cycle while the block hunts for 0xFE, reads a 16-bit function
// code and 16-bit length (MSB first), buffers the payload and checks the trailing XOR
// checksum. A good frame is emitted as one item per payload byte, the last one flagged,
// or a single item with data 0 for a zero-length frame; a bad checksum emits nothing and a
// length of P or more drops the frame on the following byte. Emission of each result goes
// through a registered read of the single payload buffer port followed by the load of the
// output register (a zero-length frame skips the read), and the input is stalled for the
// whole run; the output register lets a finished item wait while the next frame's bytes
// are taken.
module xor_checksum_frame_receiver_unit
    import xcfr_pkg::*;
#(
    parameter int P = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [15:0]       o_func_code,
    output logic [5:0]        o_payload_len,
    output logic [7:0]        o_data_byte,
    output logic [POS_W-1:0]  o_byte_pos,
    output logic              o_last_flag
);

    t_cmd cmd;
    t_sts sts;

    xcfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    xcfr_dpath #(
        .P (P)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_func_code   (o_func_code),
        .o_payload_len (o_payload_len),
        .o_data_byte   (o_data_byte),
        .o_byte_pos    (o_byte_pos),
        .o_last_flag   (o_last_flag)
    );

endmodule

// ===== bench/xcfr_checker.sv =====
// Checker for the frame receiver: predicts payload results from accepted bytes and compares them.
`timescale 1ns / 100ps

module xcfr_checker
    import xcfr_pkg::*;
#(
    parameter int P = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_func_code,
    input  logic [5:0]  i_payload_len,
    input  logic [7:0]  i_data_byte,
    input  logic [5:0]  i_byte_pos,
    input  logic        i_last_flag,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);

    typedef struct packed {
        logic [15:0] func_code;
        logic [5:0]  payload_len;
        logic [7:0]  data_byte;
        logic [5:0]  byte_pos;
        logic        last_flag;
    } t_payload_result;

    t_payload_result results_due[$];
    t_payload_result want;

    t_state      phase;
    logic [15:0] func_q;
    logic [15:0] len_q;
    logic [5:0]  fill;
    logic [7:0]  xsum;
    logic [7:0]  payload_copy [P];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < 200) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic queue_frame_results();
        t_payload_result r;
        int k;
        r.func_code   = func_q;
        r.payload_len = len_q[5:0];
        if (len_q == 16'd0) begin
            r.data_byte = 8'h00;
            r.byte_pos  = 6'd0;
            r.last_flag = 1'b1;
            results_due.push_back(r);
        end else begin
            for (k = 0; k < len_q && k < P; k++) begin
                r.data_byte = payload_copy[k];
                r.byte_pos  = 6'(k);
                r.last_flag = (k + 1 == len_q);
                results_due.push_back(r);
            end
        end
    endtask

    task automatic absorb_rx_byte(input logic [7:0] c);
        case (phase)
            S_WAIT: begin
                if (c == SOF_BYTE) begin
                    xsum  = SOF_BYTE;
                    fill  = 6'd0;
                    phase = S_FMSB;
                end
            end
            S_FMSB: begin
                func_q = {c, 8'h00};
                xsum  ^= c;
                phase  = S_FLSB;
            end
            S_FLSB: begin
                func_q[7:0] = c;
                xsum       ^= c;
                phase       = S_LMSB;
            end
            S_LMSB: begin
                len_q = {c, 8'h00};
                xsum ^= c;
                phase = S_LLSB;
            end
            S_LLSB: begin
                len_q[7:0] = c;
                xsum      ^= c;
                fill       = 6'd0;
                phase      = (len_q == 16'd0) ? S_CSUM : S_DATA;
            end
            S_DATA: begin
                if (len_q >= P) begin
                    // oversize: the byte after the header is swallowed
                    func_q = 16'd0;
                    len_q  = 16'd0;
                    fill   = 6'd0;
                    phase  = S_WAIT;
                end else begin
                    payload_copy[fill] = c;
                    xsum ^= c;
                    fill  = fill + 6'd1;
                    if ({10'd0, fill} >= len_q) begin
                        fill  = 6'd0;
                        phase = S_CSUM;
                    end
                end
            end
            S_CSUM: begin
                if (xsum == c) begin
                    queue_frame_results();
                end
                fill  = 6'd0;
                phase = S_WAIT;
            end
            default: phase = S_WAIT;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase  = S_WAIT;
            func_q = 16'd0;
            len_q  = 16'd0;
            fill   = 6'd0;
            xsum   = SOF_BYTE;
            results_due.delete();
        end else begin
            if (i_rx_valid && !i_rx_stall) begin
                absorb_rx_byte(i_rx_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result func %h pos %0d data %h",
                        i_func_code, i_byte_pos, i_data_byte));
                end else begin
                    want = results_due.pop_front();
                    if (i_func_code !== want.func_code)
                        report_mismatch($sformatf("func_code %h, want %h",
                            i_func_code, want.func_code));
                    if (i_payload_len !== want.payload_len)
                        report_mismatch($sformatf("payload_len %0d, want %0d",
                            i_payload_len, want.payload_len));
                    if (i_data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte %h, want %h at pos %0d",
                            i_data_byte, want.data_byte, want.byte_pos));
                    if (i_byte_pos !== want.byte_pos)
                        report_mismatch($sformatf("byte_pos %0d, want %0d",
                            i_byte_pos, want.byte_pos));
                    if (i_last_flag !== want.last_flag)
                        report_mismatch($sformatf("last_flag %b, want %b at pos %0d",
                            i_last_flag, want.last_flag, want.byte_pos));
                end
            end
        end
        o_pending <= results_due.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the frame receiver bench: clock, reset, byte stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module testbench
    import xcfr_pkg::*;
();

    localparam int P              = 64;
    localparam int ITEMS          = 180;
    localparam int CALM_TAIL      = 40;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] func_code;
    logic [5:0]  payload_len;
    logic [7:0]  data_byte;
    logic [5:0]  byte_pos;
    logic        last_flag;

    int fail_count;
    int pending;
    int results_seen;

    int  bytes_sent   = 0;
    int  frames_sent  = 0;
    int  holds_asked  = 0;
    int  holds_done   = 0;
    int  quiet_cycles = 0;
    bit  idle_on      = 1'b1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    xor_checksum_frame_receiver_unit #(.P(P)) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_rx_valid    (rx_valid),
        .o_rx_stall    (rx_stall),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_func_code   (func_code),
        .o_payload_len (payload_len),
        .o_data_byte   (data_byte),
        .o_byte_pos    (byte_pos),
        .o_last_flag   (last_flag)
    );

    xcfr_checker #(.P(P)) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .i_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_func_code    (func_code),
        .i_payload_len  (payload_len),
        .i_data_byte    (data_byte),
        .i_byte_pos     (byte_pos),
        .i_last_flag    (last_flag),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    always @(posedge clk) begin
        if ((rx_valid && !rx_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // output side stalls; a requested long hold lets the block back up
    initial begin
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if (holds_done < holds_asked) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit counted);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        if (counted) bytes_sent++;
    endtask

    // length of P or more: header plus the one byte that gets dropped
    task automatic send_frame(input logic [15:0] func, input logic [15:0] len,
                              input logic [7:0] sum_flip);
        logic [7:0] sum;
        logic [7:0] b;
        int k;
        sum = SOF_BYTE ^ func[15:8] ^ func[7:0] ^ len[15:8] ^ len[7:0];
        frames_sent++;
        send_byte(SOF_BYTE, 1'b1);
        send_byte(func[15:8], 1'b1);
        send_byte(func[7:0], 1'b1);
        send_byte(len[15:8], 1'b1);
        send_byte(len[7:0], 1'b1);
        if (len >= P) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b, 1'b1);
        end else begin
            for (k = 0; k < len; k++) begin
                b = 8'($urandom_range(0, 255));
                sum ^= b;
                send_byte(b, 1'b1);
            end
            send_byte(sum ^ sum_flip, 1'b1);
        end
    endtask

    task automatic drain_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        logic [15:0] func;
        logic [15:0] len;
        logic [7:0]  b;
        int sel;
        int frame_no;
        int n;

        rst_n    <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 8'h00);
        send_frame(16'h0001, 16'h0000, 8'h01);  // bad sum that equals the start byte
        send_frame(16'h0000, 16'h0001, 8'h00);
        send_frame(16'h1234, 16'h0040, 8'h00);  // smallest oversize length
        drain_results();

        frame_no = 0;
        while (bytes_sent < ITEMS) begin
            frame_no++;
            idle_on = (bytes_sent < ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            func    = 16'($urandom_range(0, 16'hFFFF));
            sel     = $urandom_range(0, 99);
            if (frame_no == 1) begin
                holds_asked++;
                send_frame(func, 16'd63, 8'h00);
                send_frame(~func, 16'($urandom_range(1, 8)), 8'h00);
            end else if (frame_no == 5) begin
                send_frame(func, 16'hFFFF, 8'h00);
                drain_results();
            end else if (sel < 8) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == SOF_BYTE) b = 8'h00;
                    send_byte(b, 1'b0);
                end
            end else if (sel < 18) begin
                len = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
                if (len < P) len = len | 16'h0040;
                send_frame(func, len, 8'h00);
            end else if (sel < 28) begin
                send_frame(func, 16'($urandom_range(0, 8)), 8'($urandom_range(1, 255)));
            end else if (sel < 33) begin
                send_frame(func, 16'($urandom_range(32, 63)), 8'h00);
            end else begin
                send_frame(func, 16'($urandom_range(0, 8)), 8'h00);
            end
        end

        idle_on = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d frames in %0d bytes, %0d payload results checked,",
                 frames_sent, bytes_sent, results_seen);
        $display("including good, bad-checksum, zero-length and oversize frames.");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/xcfr_pkg.sv
sv/xcfr_ctrl.sv
sv/xcfr_dpath.sv
sv/xor_checksum_frame_receiver_unit.sv
bench/xcfr_checker.sv
bench/testbench.sv
